/* design/fvn2d_pkg.sv */
`default_nettype none
package fvn2d_pkg;

   localparam int MAX_OCTAVES_DEF     = 8;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int COS_TABLE_BITS_DEF  = 8;

   localparam int PERS_W = 17;
   localparam int WGT_W  = 17;
   localparam int VAL_W  = 36;
   localparam int TOT_W  = 57;
   localparam int ASUM_W = 21;
   localparam int DVS_W  = 25;
   localparam int QUO_W  = 31;
   localparam int MUL_AW = 38;
   localparam int MUL_BW = 33;
   localparam int PROD_W = MUL_AW + MUL_BW;

   localparam logic [PERS_W-1:0] PERS_RESET = 17'd32768;
   localparam logic [PERS_W-1:0] PERS_ONE   = 17'd65536;
   localparam logic [31:0] HASH_MUL_Y  = 32'd57;
   localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
   localparam logic [31:0] HASH_ADD_SQ = 32'd789221;
   localparam logic [31:0] HASH_ADD_N  = 32'd1376312589;
   localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic       load;
      logic       oct_setup;
      logic       hash0;
      logic       hash1;
      logic       hash2;
      logic       accum;
      logic       blend_x0;
      logic       blend_x1;
      logic       blend_y;
      logic       total;
      logic       amp;
      logic       div_setup;
      logic       div_step;
      logic       out_load;
      logic [3:0] lat;
   } ctrl_cmd_type;

   // sin^2 weight in Q0.16 from a truncated Taylor series in Q30
   function automatic logic [WGT_W-1:0] cos_w(input int unsigned k, input int unsigned ctb);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sq;
      logic signed [63:0] s;
      x = (PI_Q30 * 64'(k)) >> (ctb + 1);
      x2 = (x * x) >> 30;
      term = ((x * x2) >> 30) / 64'd6;
      s = $signed(x) - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      s = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      s = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      s = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      s = s + $signed(term);
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      sq = ($unsigned(s) * $unsigned(s) + (64'd1 << 43)) >> 44;
      return sq[WGT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/fvn2d_req_if.sv */
`default_nettype none
interface fvn2d_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic [3:0]         octave_count;
   modport source (output valid, output coord_x, output coord_y, output octave_count,
                   input ready);
   modport sink (input valid, input coord_x, input coord_y, input octave_count,
                 output ready);
endinterface
`default_nettype wire

/* design/fvn2d_rsp_if.sv */
`default_nettype none
interface fvn2d_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] noise_value;
   modport source (output valid, output noise_value, input ready);
   modport sink (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

/* design/fractal_value_noise_2d_core.sv */
`default_nettype none
// Fractal value noise at one 2-D point.
// req channel: coord_x, coord_y (signed Q16.16) and octave_count; an item is
// taken when valid and ready are both high. ready is high whenever no item is
// in work, also while a finished result still waits on the rsp channel.
// rsp channel: noise_value, signed Q1.30, one item per request item.
// csr_write_enable / csr_write_data write persistence (Q0.16, 65536 = 1.0).
// Each octave runs 16 lattice hashes through the one shared multiplier, then
// the x and y blends and the total and amplitude updates; the final normalize
// is a 31-step restoring divider, one quotient bit per cycle.
// The block works on one item at a time; a new item can be taken from the
// cycle after the result is registered.
// Reset (synchronous, active high) empties the block, drops rsp valid and
// sets persistence to 0.5. When the receiver stalls, the result is held; a
// following item runs to completion and then waits for the output register.
module fractal_value_noise_2d_core #(
   parameter int MAX_OCTAVES     = fvn2d_pkg::MAX_OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = fvn2d_pkg::COORD_FRAC_BITS_DEF,
   parameter int COS_TABLE_BITS  = fvn2d_pkg::COS_TABLE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   fvn2d_req_if.sink                         req,
   fvn2d_rsp_if.source                       rsp,
   input  wire logic                         csr_write_enable,
   input  wire logic [fvn2d_pkg::PERS_W-1:0] csr_write_data
);

   localparam int OW = $clog2(MAX_OCTAVES + 1);

   fvn2d_pkg::ctrl_cmd_type cmd;
   logic [OW-1:0]           oct;
   logic                    last_octave;

   fvn2d_ctrl #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .last_octave (last_octave),
      .cmd         (cmd),
      .oct         (oct)
   );

   fvn2d_dpath #(
      .MAX_OCTAVES     (MAX_OCTAVES),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .COS_TABLE_BITS  (COS_TABLE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .oct              (oct),
      .last_octave      (last_octave),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .coord_x          (req.coord_x),
      .coord_y          (req.coord_y),
      .octave_count     (req.octave_count),
      .noise_value      (rsp.noise_value)
   );

endmodule
`default_nettype wire

/* design/fvn2d_ctrl.sv */
`default_nettype none
module fvn2d_ctrl #(
   parameter int MAX_OCTAVES = fvn2d_pkg::MAX_OCTAVES_DEF,
   localparam int OW = $clog2(MAX_OCTAVES + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic                    last_octave,
   output fvn2d_pkg::ctrl_cmd_type      cmd,
   output logic [OW-1:0]                oct
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_OCT  = 4'd1;
   localparam logic [3:0] S_H0   = 4'd2;
   localparam logic [3:0] S_H1   = 4'd3;
   localparam logic [3:0] S_H2   = 4'd4;
   localparam logic [3:0] S_ACC  = 4'd5;
   localparam logic [3:0] S_BX0  = 4'd6;
   localparam logic [3:0] S_BX1  = 4'd7;
   localparam logic [3:0] S_BY   = 4'd8;
   localparam logic [3:0] S_TOT  = 4'd9;
   localparam logic [3:0] S_AMP  = 4'd10;
   localparam logic [3:0] S_DSET = 4'd11;
   localparam logic [3:0] S_DIV  = 4'd12;
   localparam logic [3:0] S_FIN  = 4'd13;

   localparam logic [4:0] DIV_LAST = 5'(fvn2d_pkg::QUO_W - 1);

   logic [3:0]    state_ff, state_in;
   logic [OW-1:0] oct_ff, oct_in;
   logic [3:0]    lat_ff, lat_in;
   logic [4:0]    div_ff, div_in;
   logic          vld_ff, vld_in;
   logic          out_free;

   assign out_free  = !vld_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vld_ff;
   assign oct       = oct_ff;

   always_comb begin
      state_in = state_ff;
      oct_in   = oct_ff;
      lat_in   = lat_ff;
      div_in   = div_ff;
      vld_in   = vld_ff && !rsp_ready;
      cmd      = '0;
      cmd.lat  = lat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               oct_in   = '0;
               state_in = S_OCT;
            end
         end
         S_OCT: begin
            cmd.oct_setup = 1'b1;
            lat_in        = '0;
            state_in      = S_H0;
         end
         S_H0: begin
            cmd.hash0 = 1'b1;
            state_in  = S_H1;
         end
         S_H1: begin
            cmd.hash1 = 1'b1;
            state_in  = S_H2;
         end
         S_H2: begin
            cmd.hash2 = 1'b1;
            state_in  = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            lat_in    = lat_ff + 4'd1;
            state_in  = (lat_ff == 4'hf) ? S_BX0 : S_H0;
         end
         S_BX0: begin
            cmd.blend_x0 = 1'b1;
            state_in     = S_BX1;
         end
         S_BX1: begin
            cmd.blend_x1 = 1'b1;
            state_in     = S_BY;
         end
         S_BY: begin
            cmd.blend_y = 1'b1;
            state_in    = S_TOT;
         end
         S_TOT: begin
            cmd.total = 1'b1;
            state_in  = S_AMP;
         end
         S_AMP: begin
            cmd.amp = 1'b1;
            if (last_octave) begin
               state_in = S_DSET;
            end else begin
               oct_in   = oct_ff + OW'(1);
               state_in = S_OCT;
            end
         end
         S_DSET: begin
            cmd.div_setup = 1'b1;
            div_in        = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_in       = div_ff + 5'd1;
            if (div_ff == DIV_LAST) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               vld_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         oct_ff   <= '0;
         lat_ff   <= '0;
         div_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         oct_ff   <= oct_in;
         lat_ff   <= lat_in;
         div_ff   <= div_in;
         vld_ff   <= vld_in;
      end
   end

endmodule
`default_nettype wire

/* design/fvn2d_dpath.sv */
`default_nettype none
module fvn2d_dpath #(
   parameter int MAX_OCTAVES     = fvn2d_pkg::MAX_OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = fvn2d_pkg::COORD_FRAC_BITS_DEF,
   parameter int COS_TABLE_BITS  = fvn2d_pkg::COS_TABLE_BITS_DEF,
   localparam int OW = $clog2(MAX_OCTAVES + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fvn2d_pkg::ctrl_cmd_type             cmd,
   input  wire logic [OW-1:0]                       oct,
   output logic                                     last_octave,
   input  wire logic                                csr_write_enable,
   input  wire logic [fvn2d_pkg::PERS_W-1:0]        csr_write_data,
   input  wire logic signed [31:0]                  coord_x,
   input  wire logic signed [31:0]                  coord_y,
   input  wire logic [3:0]                          octave_count,
   output logic signed [31:0]                       noise_value
);

   localparam int VW = fvn2d_pkg::VAL_W;
   localparam int TW = fvn2d_pkg::TOT_W;
   localparam int WW = fvn2d_pkg::WGT_W;
   localparam int DW = fvn2d_pkg::DVS_W;
   localparam int QW = fvn2d_pkg::QUO_W;
   localparam int AW = fvn2d_pkg::ASUM_W;
   localparam int PW = fvn2d_pkg::PERS_W;
   localparam int CTD = 2 ** COS_TABLE_BITS;

   logic [WW-1:0] cos_rom [CTD];
   for (genvar k = 0; k < CTD; k++) begin : g_rom
      assign cos_rom[k] = fvn2d_pkg::cos_w(k, COS_TABLE_BITS);
   end

   logic [PW-1:0]        pers_ff;
   logic signed [31:0]   cx_ff, cy_ff;
   logic [OW-1:0]        cnt_ff;
   logic [31:0]          ix_ff, iy_ff;
   logic [WW-1:0]        wx_ff, wy_ff;
   logic [31:0]          n_ff, m_ff, t_ff;
   logic signed [31:0]   lat_ff;
   logic signed [VW-1:0] acc_ff [4];
   logic signed [VW-1:0] bx0_ff, bx1_ff, val_ff;
   logic signed [TW-1:0] total_ff;
   logic [PW-1:0]        amp_ff;
   logic [AW-1:0]        asum_ff;
   logic [DW-1:0]        dvs_ff, rem_ff;
   logic [QW-1:0]        q_ff;
   logic                 neg_ff;
   logic signed [31:0]   noise_ff;

   assign noise_value = noise_ff;
   assign last_octave = (oct == cnt_ff - OW'(1));

   // clamp octave count to 1 .. MAX_OCTAVES
   logic [3:0]    cnt_raw;
   logic [OW-1:0] cnt_in;
   always_comb begin
      cnt_raw = (octave_count == 4'd0) ? 4'd1 : octave_count;
      cnt_in  = (int'(cnt_raw) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(cnt_raw);
   end

   // scaled coordinates for this octave
   logic signed [63:0] sx, sy;
   logic [COS_TABLE_BITS-1:0] idx_x, idx_y;
   assign sx = 64'(cx_ff) <<< oct;
   assign sy = 64'(cy_ff) <<< oct;
   if (COORD_FRAC_BITS >= COS_TABLE_BITS) begin : g_idx_hi
      assign idx_x = sx[COORD_FRAC_BITS-1 -: COS_TABLE_BITS];
      assign idx_y = sy[COORD_FRAC_BITS-1 -: COS_TABLE_BITS];
   end else begin : g_idx_lo
      assign idx_x = {sx[COORD_FRAC_BITS-1:0], (COS_TABLE_BITS-COORD_FRAC_BITS)'(0)};
      assign idx_y = {sy[COORD_FRAC_BITS-1:0], (COS_TABLE_BITS-COORD_FRAC_BITS)'(0)};
   end

   // lattice point for hash: offsets -1 .. 2 around (ix, iy)
   logic [31:0] hx, hy, n0, n1;
   always_comb begin
      hx = ix_ff + 32'(cmd.lat[1:0]) - 32'd1;
      hy = iy_ff + 32'(cmd.lat[3:2]) - 32'd1;
      n0 = hx + hy * fvn2d_pkg::HASH_MUL_Y;
      n1 = (n0 << 13) ^ n0;
   end

   // shared multiplier
   logic signed [fvn2d_pkg::MUL_AW-1:0] mul_a;
   logic signed [fvn2d_pkg::MUL_BW-1:0] mul_b;
   logic signed [fvn2d_pkg::PROD_W-1:0] prod, prod_sh;
   logic signed [VW:0]                  diff;
   logic [PW-1:0]                       pers_c;

   assign pers_c = (pers_ff > fvn2d_pkg::PERS_ONE) ? fvn2d_pkg::PERS_ONE : pers_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      diff  = '0;
      if (cmd.hash0) begin
         mul_a = $signed({6'b0, n1});
         mul_b = $signed({1'b0, n1});
      end else if (cmd.hash1) begin
         mul_a = $signed({6'b0, m_ff});
         mul_b = $signed({1'b0, fvn2d_pkg::HASH_MUL_SQ});
      end else if (cmd.hash2) begin
         mul_a = $signed({6'b0, n_ff});
         mul_b = $signed({1'b0, t_ff});
      end else if (cmd.blend_x0) begin
         diff  = (VW+1)'(acc_ff[1]) - (VW+1)'(acc_ff[0]);
         mul_a = fvn2d_pkg::MUL_AW'(diff);
         mul_b = $signed({16'b0, wx_ff});
      end else if (cmd.blend_x1) begin
         diff  = (VW+1)'(acc_ff[3]) - (VW+1)'(acc_ff[2]);
         mul_a = fvn2d_pkg::MUL_AW'(diff);
         mul_b = $signed({16'b0, wx_ff});
      end else if (cmd.blend_y) begin
         diff  = (VW+1)'(bx1_ff) - (VW+1)'(bx0_ff);
         mul_a = fvn2d_pkg::MUL_AW'(diff);
         mul_b = $signed({16'b0, wy_ff});
      end else if (cmd.total) begin
         mul_a = fvn2d_pkg::MUL_AW'(val_ff);
         mul_b = $signed({16'b0, amp_ff});
      end else if (cmd.amp) begin
         mul_a = $signed({21'b0, amp_ff});
         mul_b = $signed({16'b0, pers_c});
      end
      prod    = mul_a * mul_b;
      prod_sh = prod >>> 16;
   end

   logic [31:0] hash_v;
   assign hash_v = (prod[31:0] + fvn2d_pkg::HASH_ADD_N) & fvn2d_pkg::HASH_MASK;

   // corner k = a + 2b takes lattice (dx, dy) when dx lies in a .. a+2 and dy in b .. b+2;
   // weight doubles per axis that sits at the center
   logic signed [VW-1:0] acc_in [4];
   always_comb begin
      logic [2:0] dx, dy, a, b;
      logic [1:0] sh;
      dx = {1'b0, cmd.lat[1:0]};
      dy = {1'b0, cmd.lat[3:2]};
      for (int k = 0; k < 4; k++) begin
         a  = 3'(k & 1);
         b  = 3'(k >> 1);
         sh = 2'(dx == a + 3'd1) + 2'(dy == b + 3'd1);
         acc_in[k] = acc_ff[k];
         if (dx >= a && dx <= a + 3'd2 && dy >= b && dy <= b + 3'd2)
            acc_in[k] = acc_ff[k] + (VW'(lat_ff) <<< sh);
      end
   end

   // divider
   logic [DW:0]          r2;
   logic                 ge;
   logic signed [TW-1:0] mag;
   assign r2  = {rem_ff, q_ff[QW-1]};
   assign ge  = (r2 >= {1'b0, dvs_ff});
   assign mag = total_ff[TW-1] ? -total_ff : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pers_ff <= fvn2d_pkg::PERS_RESET;
      end else if (csr_write_enable) begin
         pers_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= coord_x;
         cy_ff    <= coord_y;
         cnt_ff   <= cnt_in;
         amp_ff   <= fvn2d_pkg::PERS_ONE;
         asum_ff  <= '0;
         total_ff <= '0;
      end
      if (cmd.oct_setup) begin
         ix_ff <= sx[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
         iy_ff <= sy[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
         wx_ff <= cos_rom[idx_x];
         wy_ff <= cos_rom[idx_y];
         for (int k = 0; k < 4; k++) acc_ff[k] <= '0;
      end
      if (cmd.hash0) begin
         n_ff <= n1;
         m_ff <= prod[31:0];
      end
      if (cmd.hash1) t_ff <= prod[31:0] + fvn2d_pkg::HASH_ADD_SQ;
      if (cmd.hash2) lat_ff <= fvn2d_pkg::ONE_Q30 - $signed(hash_v);
      if (cmd.accum) begin
         for (int k = 0; k < 4; k++) acc_ff[k] <= acc_in[k];
      end
      if (cmd.blend_x0) bx0_ff <= acc_ff[0] + prod_sh[VW-1:0];
      if (cmd.blend_x1) bx1_ff <= acc_ff[2] + prod_sh[VW-1:0];
      if (cmd.blend_y)  val_ff <= bx0_ff + prod_sh[VW-1:0];
      if (cmd.total)    total_ff <= total_ff + prod[TW-1:0];
      if (cmd.amp) begin
         amp_ff  <= prod[32:16];
         asum_ff <= asum_ff + AW'(amp_ff);
      end
      if (cmd.div_setup) begin
         dvs_ff <= {asum_ff, 4'b0};
         neg_ff <= total_ff[TW-1];
         rem_ff <= mag[TW-2:QW];
         q_ff   <= mag[QW-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DW'(r2 - {1'b0, dvs_ff}) : r2[DW-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
      end
      if (cmd.out_load) noise_ff <= neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   end

endmodule
`default_nettype wire

/* tb/fractal_value_noise_2d_core_tb.sv */
module fractal_value_noise_2d_core_tb;

   localparam int FRAC_BITS = fvn2d_pkg::COORD_FRAC_BITS_DEF;
   localparam int TAB_BITS  = fvn2d_pkg::COS_TABLE_BITS_DEF;
   localparam int OCT_MAX   = fvn2d_pkg::MAX_OCTAVES_DEF;
   localparam int PW        = fvn2d_pkg::PERS_W;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [PW-1:0] csr_write_data;
   int   mismatch_count;
   longint cycle_count = 0;
   bit   rsp_hold;
   bit   rsp_hold_done;
   bit   hold_go;

   fvn2d_req_if req ();
   fvn2d_rsp_if rsp ();

   fractal_value_noise_2d_core i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   class noise_scoreboard;
      logic [PW-1:0] persistence;
      logic signed [31:0] pending_noise[$];
      longint weight_rom[1 << TAB_BITS];

      function new();
         persistence = fvn2d_pkg::PERS_RESET;
         for (int k = 0; k < (1 << TAB_BITS); k++) weight_rom[k] = sin_sq_weight(k);
      endfunction

      function longint sin_sq_weight(input int k);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint s;
         x = (longint'(fvn2d_pkg::PI_Q30) * longint'(k)) >> (TAB_BITS + 1);
         x2 = (x * x) >> 30;
         term = x;
         s = x;
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2) s -= term;
            else s += term;
         end
         if (s < 0) s = 0;
         if (s > 64'sd1073741824) s = 64'sd1073741824;
         return (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
      endfunction

      function longint lattice_value(input bit [31:0] x, input bit [31:0] y);
         bit [31:0] n;
         n = x + y * 32'd57;
         n = (n << 13) ^ n;
         n = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
         return 64'sd1073741824 - longint'({32'd0, n});
      endfunction

      function longint smooth_value(input bit [31:0] x, input bit [31:0] y);
         longint c;
         longint s;
         c = lattice_value(x - 1, y - 1) + lattice_value(x + 1, y - 1)
           + lattice_value(x - 1, y + 1) + lattice_value(x + 1, y + 1);
         s = lattice_value(x - 1, y) + lattice_value(x + 1, y)
           + lattice_value(x, y - 1) + lattice_value(x, y + 1);
         return c + 2 * s + 4 * lattice_value(x, y);
      endfunction

      function longint mix(input longint a, input longint b, input longint w);
         return a + ((b - a) * w >>> 16);
      endfunction

      function longint octave_noise(input longint sx, input longint sy);
         bit [31:0] ix;
         bit [31:0] iy;
         longint wx;
         longint wy;
         ix = 32'(sx >>> FRAC_BITS);
         iy = 32'(sy >>> FRAC_BITS);
         wx = weight_rom[(sx & ((64'd1 << FRAC_BITS) - 1)) >> (FRAC_BITS - TAB_BITS)];
         wy = weight_rom[(sy & ((64'd1 << FRAC_BITS) - 1)) >> (FRAC_BITS - TAB_BITS)];
         return mix(mix(smooth_value(ix, iy), smooth_value(ix + 1, iy), wx),
                    mix(smooth_value(ix, iy + 1), smooth_value(ix + 1, iy + 1), wx), wy);
      endfunction

      function void note_request(input logic signed [31:0] cx, input logic signed [31:0] cy,
                                 input logic [3:0] cnt);
         longint p;
         longint amp;
         longint total;
         longint amp_sum;
         int oct;
         p = (persistence > fvn2d_pkg::PERS_ONE) ? longint'(fvn2d_pkg::PERS_ONE)
                                                 : longint'(persistence);
         oct = (cnt < 1) ? 1 : (cnt > OCT_MAX) ? OCT_MAX : int'(cnt);
         amp = 65536;
         total = 0;
         amp_sum = 0;
         for (int i = 0; i < oct; i++) begin
            total += octave_noise(longint'(cx) <<< i, longint'(cy) <<< i) * amp;
            amp_sum += amp;
            amp = (amp * p) >> 16;
         end
         pending_noise.insert(pending_noise.size(), 32'(total / (amp_sum * 16)));
      endfunction

      task check_noise(input logic signed [31:0] got);
         logic signed [31:0] want;
         if (pending_noise.size() == 0) begin
            report_mismatch($sformatf("unexpected noise_value %0d", got));
            return;
         end
         want = pending_noise.pop_front();
         if (got !== want)
            report_mismatch($sformatf("noise_value got %0d want %0d", got, want));
      endtask
   endclass

   noise_scoreboard sb;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side
   bit rsp_calm;
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_request(req.coord_x, req.coord_y, req.octave_count);
         if (rsp.valid && rsp.ready) sb.check_noise(rsp.noise_value);
      end
      rsp.ready <= !rsp_hold && (rsp_calm || $urandom_range(99) >= 25);
   end

   // long receiver stall while the sender keeps offering items
   initial begin
      rsp_hold = 0;
      rsp_hold_done = 0;
      wait (hold_go);
      @(posedge clock);
      rsp_hold = 1;
      repeat (3000) @(posedge clock);
      rsp_hold = 0;
      rsp_hold_done = 1;
   end

   task automatic send_item(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [3:0] cnt, input bit calm);
      while (!calm && $urandom_range(99) < 25) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.coord_x <= cx;
      req.coord_y <= cy;
      req.octave_count <= cnt;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic set_persistence(input logic [PW-1:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= value;
      sb.persistence = value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [3:0] pick_count();
      // mostly few octaves to keep the run short
      if ($urandom_range(9) == 0) return 4'($urandom_range(15));
      return 4'($urandom_range(3, 1));
   endfunction

   initial begin
      logic [PW-1:0] pers_list[6];
      sb = new();
      mismatch_count = 0;
      rsp_calm = 0;
      hold_go = 0;
      reset = 1;
      req.valid = 0;
      req.coord_x = 0;
      req.coord_y = 0;
      req.octave_count = 1;
      rsp.ready = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // coordinate and octave extremes at reset persistence, then persistence extremes
      send_item(0, 0, 1, 0);
      send_item(32'h7fffffff, 32'h7fffffff, 8, 0);
      send_item(32'h80000000, 32'h80000000, 8, 0);
      send_item(32'h80000000, 32'h7fffffff, 4, 0);
      send_item(32'h0000ffff, 32'hffff0000, 0, 0);
      send_item(32'hffffffff, 32'h00010000, 15, 0);
      send_item(32'h12345678, 32'h9abcdef0, 9, 0);
      set_persistence(0);
      send_item(32'h00018000, 32'hfffe8000, 8, 0);
      set_persistence(fvn2d_pkg::PERS_ONE);
      send_item(32'h00018000, 32'hfffe8000, 8, 0);
      set_persistence(17'h1ffff);
      send_item(32'h7fff0000, 32'h80000001, 8, 0);
      send_item(32'h55555555, 32'haaaaaaaa, 2, 0);

      pers_list = '{17'd32768, 17'd1, 17'd65535, 17'd49152, 17'h10001, 17'd0};
      for (int ph = 0; ph < 6; ph++) begin
         set_persistence(pers_list[ph]);
         for (int n = 0; n < 65; n++) begin
            rsp_calm = (ph == 2);
            if (ph == 1 && n == 5) hold_go = 1;
            send_item($urandom, $urandom, pick_count(), ph == 2);
         end
         if (ph == 3) begin
            // sender pause until all results are back
            drain();
         end
      end
      rsp_calm = 0;
      req.valid <= 0;
      wait (rsp_hold_done);
      while (sb.pending_noise.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
